FILE: src/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types for the sliding window maximum block: payload structs and
// the command/status bundles between controller and datapath. No dependencies.
package swm_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_WIDTH    = 7;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           end_of_array;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           final_window;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming request
    logic rd_back;    // read the deque back entry
    logic drop_back;  // drop the deque back entry
    logic push;       // append sample, write ring, read front and oldest
    logic emit;       // load the output register, retire the front if it expires
    logic finish;     // advance the ring, clear on end of array
  } swm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;  // deque is empty
    logic back_lt;   // registered back entry is below the held sample
    logic produce;   // window is full after this sample
    logic out_free;  // output register can take a result
  } swm_sts_t;

endpackage

FILE: src/swm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sliding window maximum block.
// Depends on swm_pkg for the command and status structs.
module swm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDB  = 5'b00010,
    S_CMP  = 5'b00100,
    S_PUSH = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        cmd.rd_back = 1'b1;
        state_nxt   = sts.cnt_zero ? S_PUSH : S_CMP;
      end
      S_CMP: begin
        if (sts.back_lt) begin
          cmd.drop_back = 1'b1;
          state_nxt     = S_RDB;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (sts.produce) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  a_push_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && sts.produce) |=> state_r == S_EMIT)
    else $error("full window did not lead to emit");

  a_cmp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> !sts.cnt_zero)
    else $error("back compare on an empty deque");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

FILE: src/swm_datapath.sv
`timescale 1ns / 1ps
// Datapath: candidate deque memory, recent-sample ring memory, counters,
// window register and output register. Depends on swm_pkg.
module swm_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swm_pkg::in_item_t                  in_data,
  input  logic                               cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  input  swm_pkg::swm_cmd_t                  cmd,
  output swm_pkg::swm_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output swm_pkg::out_item_t                 out_data
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = IDX_W + 2;
  localparam int KW    = (CNT_W > swm_pkg::CFG_WIDTH) ? CNT_W : swm_pkg::CFG_WIDTH;
  localparam int SW    = swm_pkg::SAMPLE_WIDTH;

  logic signed [SW-1:0] dq_mem [MAX_WINDOW];
  logic signed [SW-1:0] rg_mem [MAX_WINDOW];

  logic signed [SW-1:0] s_r, dq_rd_r, rg_rd_r;
  logic                 last_r, front_byp_r, ring_byp_r;
  logic [IDX_W-1:0]     head_r, head_nxt, pos_r, pos_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt, fill_r, fill_nxt, fill_inc;
  logic [swm_pkg::CFG_WIDTH-1:0] ws_r;
  logic                 out_valid_r, out_valid_nxt;
  swm_pkg::out_item_t   out_data_r;

  logic [KW-1:0]        ws_ext;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     km1;
  logic [IDX_W-1:0]     back_idx, tail_idx, rd_idx, oldest_idx;
  logic signed [SW-1:0] front_val, old_val;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum >= SUM_W'(MAX_WINDOW)) begin
      sum = sum - SUM_W'(MAX_WINDOW);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Effective window: zero reads as one, oversize saturates.
  always_comb begin
    ws_ext = KW'(ws_r);
    if (ws_ext == '0) begin
      k = CNT_W'(1);
    end else if (ws_ext > KW'(MAX_WINDOW)) begin
      k = CNT_W'(MAX_WINDOW);
    end else begin
      k = CNT_W'(ws_ext);
    end
    km1 = k - CNT_W'(1);
  end

  assign back_idx = (count_r == '0) ? head_r : wrap_add(head_r, count_r - CNT_W'(1));
  assign tail_idx = wrap_add(head_r, count_r);
  assign rd_idx   = cmd.push ? head_r : back_idx;

  always_comb begin
    logic [SUM_W-1:0] diff;
    if (SUM_W'(pos_r) >= SUM_W'(km1)) begin
      diff = SUM_W'(pos_r) - SUM_W'(km1);
    end else begin
      diff = SUM_W'(pos_r) + SUM_W'(MAX_WINDOW) - SUM_W'(km1);
    end
    oldest_idx = diff[IDX_W-1:0];
  end

  assign fill_inc  = (fill_r < k) ? fill_r + CNT_W'(1) : fill_r;
  assign front_val = front_byp_r ? s_r : dq_rd_r;
  assign old_val   = ring_byp_r ? s_r : rg_rd_r;

  assign sts.cnt_zero = (count_r == '0);
  assign sts.back_lt  = (dq_rd_r < s_r);
  assign sts.produce  = (fill_inc >= k);
  assign sts.out_free = !out_valid_r || out_ready;

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.push && count_r < CNT_W'(MAX_WINDOW)) begin
      dq_mem[tail_idx] <= s_r;
    end
    if (cmd.rd_back || cmd.push) begin
      dq_rd_r <= dq_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rg_mem[pos_r] <= s_r;
      rg_rd_r       <= rg_mem[oldest_idx];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.drop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.push) begin
      if (count_r < CNT_W'(MAX_WINDOW)) begin
        count_nxt = count_r + CNT_W'(1);
      end
      fill_nxt = fill_inc;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      // retire the front once its sample leaves the window
      if (front_val == old_val && count_r != '0) begin
        head_nxt  = wrap_add(head_r, CNT_W'(1));
        count_nxt = count_r - CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      pos_nxt = (pos_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : pos_r + IDX_W'(1);
      if (last_r) begin
        head_nxt  = '0;
        count_nxt = '0;
        pos_nxt   = '0;
        fill_nxt  = '0;
      end
    end
    if (cfg_we) begin
      head_nxt  = '0;
      count_nxt = '0;
      pos_nxt   = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      ws_r        <= swm_pkg::CFG_WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ws_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= in_data.sample;
      last_r <= in_data.end_of_array;
    end
    if (cmd.push) begin
      front_byp_r <= (count_r == '0);
      ring_byp_r  <= (k == CNT_W'(1));
    end
    if (cmd.emit) begin
      out_data_r.window_max   <= front_val;
      out_data_r.final_window <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WINDOW))
    else $error("deque count past capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k)
    else $error("fill level past window size");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending one");

  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && last_r) |=> (count_r == '0 && fill_r == '0 && pos_r == '0))
    else $error("state not cleared after end of array");

endmodule

FILE: src/sliding_window_maximum.sv
`timescale 1ns / 1ps
// Sliding window maximum over a signed sample stream, one request at a time.
// Per request: the sample is accepted, the back entry is read and compared, and entries
// below the sample are popped through the deque read port; the sample is then pushed and,
// once the window is full, the result loads. Input is ready in the cycle after the result
// loads, or after the push if none is due; a stalled output holds only the emit step.
// rst_n is synchronous: counters, window size (1) and output valid clear; memories do not.
module sliding_window_maximum #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  swm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  swm_pkg::swm_cmd_t cmd;
  swm_pkg::swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
